### design/csrgb_pkg.sv
`default_nettype none
package csrgb_pkg;

   localparam int CHANNELS  = 3;
   localparam int CAL_BITS  = 20;
   localparam int DIV_BITS  = 8;
   localparam int GATE_BITS = 10;
   localparam int RGB_BITS  = 8;
   localparam int QUO_BITS  = RGB_BITS + 1;
   localparam int STEP_BITS = $clog2(QUO_BITS);
   localparam int CSR_BITS  = 3;

   localparam logic [DIV_BITS-1:0]  DIVISOR_RESET = DIV_BITS'(10);
   localparam logic [CAL_BITS-1:0]  DARK_RESET    = CAL_BITS'(6000);
   localparam logic [CAL_BITS-1:0]  WHITE_RESET   = CAL_BITS'(55000);
   localparam int                   GATE_SPAN     = 1000;
   localparam logic [GATE_BITS-1:0] GATE_MAX      = '1;
   localparam logic [RGB_BITS-1:0]  RGB_MAX       = '1;

   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_SAMPLE_DIVISOR = 3'd0,
      CSR_DARK_RED       = 3'd1,
      CSR_DARK_GREEN     = 3'd2,
      CSR_DARK_BLUE      = 3'd3,
      CSR_WHITE_RED      = 3'd4,
      CSR_WHITE_GREEN    = 3'd5,
      CSR_WHITE_BLUE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic       accept;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic       out_load;
      logic [1:0] ch;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_gate;
   } ctl_status_type;

endpackage
`default_nettype wire

### design/csrgb_ctrl.sv
`default_nettype none
module csrgb_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire csrgb_pkg::ctl_status_type status,
   output csrgb_pkg::ctl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_READY,
      ST_LOAD,
      ST_STEP,
      ST_STORE,
      ST_DONE
   } state_type;

   state_type                       state_ff;
   logic                            rsp_valid_ff;
   logic [1:0]                      ch_ff;
   logic [csrgb_pkg::STEP_BITS-1:0] step_ff;
   logic                            ready;
   logic                            accept;

   assign ready     = (state_ff == ST_READY) && (!rsp_valid_ff || !rsp_stall);
   assign accept    = req_valid && ready;
   assign req_stall = !ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.div_load  = (state_ff == ST_LOAD);
      cmd.div_step  = (state_ff == ST_STEP);
      cmd.div_store = (state_ff == ST_STORE);
      cmd.out_load  = (accept && !status.last_gate) || (state_ff == ST_DONE);
      cmd.ch        = ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= csrgb_pkg::COLOR_RED;
         step_ff      <= '0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_READY: begin
               if (accept && status.last_gate) begin
                  state_ff <= ST_LOAD;
                  ch_ff    <= csrgb_pkg::COLOR_RED;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_STEP;
               step_ff  <= '0;
            end
            ST_STEP: begin
               if (step_ff == csrgb_pkg::STEP_BITS'(csrgb_pkg::QUO_BITS - 1)) begin
                  state_ff <= ST_STORE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_STORE: begin
               if (ch_ff == csrgb_pkg::COLOR_BLUE) begin
                  state_ff <= ST_DONE;
               end else begin
                  ch_ff    <= ch_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_DONE: begin
               state_ff <= ST_READY;
            end
            default: begin
               state_ff <= ST_READY;
            end
         endcase
      end
   end

   a_last_gate_starts_calib: assert property (@(posedge clock) disable iff (reset)
      accept && status.last_gate |=> state_ff == ST_LOAD)
      else $error("closing request did not start calibration");

   a_plain_request_answered: assert property (@(posedge clock) disable iff (reset)
      accept && !status.last_gate |=> rsp_valid_ff)
      else $error("request without response");

   a_blue_store_finishes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE && ch_ff == csrgb_pkg::COLOR_BLUE |=> state_ff == ST_DONE)
      else $error("calibration did not finish after blue");

   a_done_gives_response: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff)
      else $error("finished reading without response");

endmodule
`default_nettype wire

### design/csrgb_datapath.sv
`default_nettype none
module csrgb_datapath #(
   parameter int RAW_BITS = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_cmd,
   input  wire logic                                 req_pulse_edge,
   input  wire logic                                 req_ms_tick,
   input  wire logic                                 csr_write_enable,
   input  wire logic [csrgb_pkg::CSR_BITS-1:0]       csr_index,
   input  wire logic [csrgb_pkg::CAL_BITS-1:0]       csr_write_data,
   input  wire csrgb_pkg::ctl_cmd_type               cmd,
   output csrgb_pkg::ctl_status_type                 status,
   output logic                                      rsp_sensor_enable,
   output logic                                      rsp_filter_s2,
   output logic                                      rsp_filter_s3,
   output logic                                      rsp_done_res,
   output logic [csrgb_pkg::RGB_BITS-1:0]            rsp_red,
   output logic [csrgb_pkg::RGB_BITS-1:0]            rsp_green,
   output logic [csrgb_pkg::RGB_BITS-1:0]            rsp_blue,
   output logic [RAW_BITS-1:0]                       rsp_raw_red,
   output logic [RAW_BITS-1:0]                       rsp_raw_green,
   output logic [RAW_BITS-1:0]                       rsp_raw_blue
);

   localparam int CH      = csrgb_pkg::CHANNELS;
   localparam int CALW    = csrgb_pkg::CAL_BITS;
   localparam int RGBW    = csrgb_pkg::RGB_BITS;
   localparam int GW      = csrgb_pkg::GATE_BITS;
   localparam int DIFF_W  = ((RAW_BITS > CALW) ? RAW_BITS : CALW) + 1;
   localparam int NUM_W   = DIFF_W + RGBW;
   localparam int PROD_W  = RAW_BITS + csrgb_pkg::DIV_BITS;
   localparam int GPROD_W = GW + 1 + csrgb_pkg::DIV_BITS;
   localparam logic [RAW_BITS-1:0] RAW_MAX = '1;

   // configuration
   logic [csrgb_pkg::DIV_BITS-1:0] divisor_ff;
   logic [CALW-1:0]                dark_ff  [CH];
   logic [CALW-1:0]                white_ff [CH];

   // reading state
   logic                 counting_ff, counting_in;
   logic [1:0]           color_ff, color_in;
   logic [GW-1:0]        gate_ff, gate_in;
   logic [RAW_BITS-1:0]  edge_count_ff, edge_count_in;
   logic [RAW_BITS-1:0]  raw_ff [CH];
   logic [RAW_BITS-1:0]  raw_in [CH];
   logic [RGBW-1:0]      rgb_ff [CH];
   logic [RGBW-1:0]      rgb_in [CH];

   // shared divider
   logic [NUM_W-1:0]               rem_ff, rem_in;
   logic [NUM_W-1:0]               dsh_ff, dsh_in;
   logic [csrgb_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic                           zero_ff, zero_in;

   // output register
   logic                 out_enable_ff, out_s2_ff, out_s3_ff, out_done_ff;
   logic [RGBW-1:0]      out_rgb_ff [CH];
   logic [RAW_BITS-1:0]  out_raw_ff [CH];

   logic [RAW_BITS-1:0]  edge_upd;
   logic [GW-1:0]        gate_upd;
   logic [GPROD_W-1:0]   gate_prod;
   logic                 gate_close;
   logic [PROD_W-1:0]    raw_prod;
   logic [RAW_BITS-1:0]  raw_sat;
   logic [DIFF_W-1:0]    diff, den, diff_mag, den_mag;
   logic                 ge;
   logic [RGBW-1:0]      div_result;
   logic                 s2_in, s3_in;
   logic                 done_in;

   assign edge_upd = (req_pulse_edge && (edge_count_ff != RAW_MAX)) ?
                     edge_count_ff + 1'b1 : edge_count_ff;
   assign gate_upd = (gate_ff != csrgb_pkg::GATE_MAX) ? gate_ff + 1'b1 : gate_ff;
   // gate closes when elapsed >= floor(1000/div), i.e. (elapsed+1)*div > 1000
   assign gate_prod = GPROD_W'({1'b0, gate_upd} + (GW + 1)'(1)) * GPROD_W'(divisor_ff);
   assign gate_close = counting_ff && req_ms_tick &&
                       (gate_prod > GPROD_W'(csrgb_pkg::GATE_SPAN));
   assign raw_prod = PROD_W'(edge_upd) * PROD_W'(divisor_ff);
   assign raw_sat  = (|raw_prod[PROD_W-1:RAW_BITS]) ? RAW_MAX : raw_prod[RAW_BITS-1:0];

   assign status.last_gate = !req_cmd && gate_close && (color_ff == csrgb_pkg::COLOR_BLUE);

   always_comb begin
      counting_in   = counting_ff;
      color_in      = color_ff;
      gate_in       = gate_ff;
      edge_count_in = edge_count_ff;
      raw_in        = raw_ff;
      done_in       = 1'b0;
      if (cmd.accept) begin
         if (req_cmd) begin
            counting_in   = 1'b1;
            color_in      = csrgb_pkg::COLOR_RED;
            gate_in       = '0;
            edge_count_in = '0;
         end else if (counting_ff) begin
            edge_count_in = edge_upd;
            if (req_ms_tick) begin
               if (gate_close) begin
                  raw_in[color_ff] = raw_sat;
                  gate_in          = '0;
                  edge_count_in    = '0;
                  if (color_ff == csrgb_pkg::COLOR_BLUE) begin
                     counting_in = 1'b0;
                  end else begin
                     color_in = color_ff + 1'b1;
                  end
               end else begin
                  gate_in = gate_upd;
               end
            end
         end
      end else begin
         done_in = 1'b1;
      end
   end

   always_comb begin
      case (color_in)
         csrgb_pkg::COLOR_RED: begin
            s2_in = 1'b0;
            s3_in = 1'b0;
         end
         csrgb_pkg::COLOR_GREEN: begin
            s2_in = 1'b1;
            s3_in = 1'b1;
         end
         csrgb_pkg::COLOR_BLUE: begin
            s2_in = 1'b0;
            s3_in = 1'b1;
         end
         default: begin
            s2_in = 1'b1;
            s3_in = 1'b0;
         end
      endcase
   end

   // magnitudes of raw-dark and white-dark, sign handled by zero flag
   assign diff     = DIFF_W'(raw_ff[cmd.ch]) - DIFF_W'(dark_ff[cmd.ch]);
   assign den      = DIFF_W'(white_ff[cmd.ch]) - DIFF_W'(dark_ff[cmd.ch]);
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
   assign den_mag  = den[DIFF_W-1] ? DIFF_W'(-den) : den;
   assign ge       = (rem_ff >= dsh_ff);
   assign div_result = zero_ff ? '0 :
                       (quo_ff[csrgb_pkg::QUO_BITS-1] ? csrgb_pkg::RGB_MAX :
                                                        quo_ff[RGBW-1:0]);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      if (cmd.div_load) begin
         rem_in  = (NUM_W'(diff_mag) << RGBW) - NUM_W'(diff_mag);
         dsh_in  = NUM_W'(den_mag) << RGBW;
         quo_in  = '0;
         zero_in = (den == '0) || (diff[DIFF_W-1] != den[DIFF_W-1]);
      end else if (cmd.div_step) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[csrgb_pkg::QUO_BITS-2:0], ge};
      end
   end

   always_comb begin
      rgb_in = rgb_ff;
      if (cmd.div_store) begin
         rgb_in[cmd.ch] = div_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= csrgb_pkg::DIVISOR_RESET;
         for (int i = 0; i < CH; i++) begin
            dark_ff[i]  <= csrgb_pkg::DARK_RESET;
            white_ff[i] <= csrgb_pkg::WHITE_RESET;
         end
      end else if (csr_write_enable) begin
         case (csrgb_pkg::csr_index_type'(csr_index))
            csrgb_pkg::CSR_SAMPLE_DIVISOR: begin
               if (csr_write_data[csrgb_pkg::DIV_BITS-1:0] != '0) begin
                  divisor_ff <= csr_write_data[csrgb_pkg::DIV_BITS-1:0];
               end
            end
            csrgb_pkg::CSR_DARK_RED:    dark_ff[0]  <= csr_write_data;
            csrgb_pkg::CSR_DARK_GREEN:  dark_ff[1]  <= csr_write_data;
            csrgb_pkg::CSR_DARK_BLUE:   dark_ff[2]  <= csr_write_data;
            csrgb_pkg::CSR_WHITE_RED:   white_ff[0] <= csr_write_data;
            csrgb_pkg::CSR_WHITE_GREEN: white_ff[1] <= csr_write_data;
            csrgb_pkg::CSR_WHITE_BLUE:  white_ff[2] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counting_ff   <= 1'b0;
         color_ff      <= csrgb_pkg::COLOR_RED;
         gate_ff       <= '0;
         edge_count_ff <= '0;
         for (int i = 0; i < CH; i++) begin
            raw_ff[i] <= '0;
            rgb_ff[i] <= '0;
         end
      end else begin
         counting_ff   <= counting_in;
         color_ff      <= color_in;
         gate_ff       <= gate_in;
         edge_count_ff <= edge_count_in;
         raw_ff        <= raw_in;
         rgb_ff        <= rgb_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      if (cmd.out_load) begin
         out_enable_ff <= counting_in;
         out_s2_ff     <= s2_in;
         out_s3_ff     <= s3_in;
         out_done_ff   <= done_in;
         out_rgb_ff    <= rgb_in;
         out_raw_ff    <= raw_in;
      end
   end

   assign rsp_sensor_enable = out_enable_ff;
   assign rsp_filter_s2     = out_s2_ff;
   assign rsp_filter_s3     = out_s3_ff;
   assign rsp_done_res      = out_done_ff;
   assign rsp_red           = out_rgb_ff[0];
   assign rsp_green         = out_rgb_ff[1];
   assign rsp_blue          = out_rgb_ff[2];
   assign rsp_raw_red       = out_raw_ff[0];
   assign rsp_raw_green     = out_raw_ff[1];
   assign rsp_raw_blue      = out_raw_ff[2];

endmodule
`default_nettype wire

### design/color_sensor_rgb_readout.sv
`default_nettype none
// Colour sensor readout with two-point calibration. Each request is one clock sample of
// start command, sensor pulse edge and millisecond tick, and each request gives exactly
// one response. Requests that do not close the blue gate are taken one per cycle unless
// rsp_stall holds a response, with the response registered in the next cycle. The
// request closing the blue gate stalls later requests while one shared restoring divider
// maps red, green and blue in turn, one quotient bit per cycle (load, nine steps, store
// per channel, then the response). Configuration is written through csr_write_enable,
// csr_index and csr_write_data; writes of zero to the sample divisor are ignored.
module color_sensor_rgb_readout #(
   parameter int RAW_BITS = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_cmd,
   input  wire logic                           req_pulse_edge,
   input  wire logic                           req_ms_tick,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_sensor_enable,
   output logic                                rsp_filter_s2,
   output logic                                rsp_filter_s3,
   output logic                                rsp_done_res,
   output logic [csrgb_pkg::RGB_BITS-1:0]      rsp_red,
   output logic [csrgb_pkg::RGB_BITS-1:0]      rsp_green,
   output logic [csrgb_pkg::RGB_BITS-1:0]      rsp_blue,
   output logic [RAW_BITS-1:0]                 rsp_raw_red,
   output logic [RAW_BITS-1:0]                 rsp_raw_green,
   output logic [RAW_BITS-1:0]                 rsp_raw_blue,
   input  wire logic                           csr_write_enable,
   input  wire logic [csrgb_pkg::CSR_BITS-1:0] csr_index,
   input  wire logic [csrgb_pkg::CAL_BITS-1:0] csr_write_data
);

   csrgb_pkg::ctl_cmd_type    cmd;
   csrgb_pkg::ctl_status_type status;

   csrgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   csrgb_datapath #(
      .RAW_BITS (RAW_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_pulse_edge    (req_pulse_edge),
      .req_ms_tick       (req_ms_tick),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_sensor_enable (rsp_sensor_enable),
      .rsp_filter_s2     (rsp_filter_s2),
      .rsp_filter_s3     (rsp_filter_s3),
      .rsp_done_res      (rsp_done_res),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_raw_red       (rsp_raw_red),
      .rsp_raw_green     (rsp_raw_green),
      .rsp_raw_blue      (rsp_raw_blue)
   );

endmodule
`default_nettype wire
